FILE: rtl/tdts_pkg.sv
package tdts_pkg;

	localparam int LINE_W = 16;
	localparam int COL_W = 10;
	localparam int LEN_W = 10;

	localparam int LENGTH_LIMIT_DEF = 1023;
	localparam int QUEUE_DEPTH_DEF = 4;

	// character classes seen by the scanner
	typedef enum logic [3:0] {
		CL_SYM    = 4'd0,
		CL_DIGIT  = 4'd1,
		CL_LETTER = 4'd2,
		CL_SLASH  = 4'd3,
		CL_STAR   = 4'd4,
		CL_REL    = 4'd5,
		CL_EQ     = 4'd6,
		CL_BANG   = 4'd7,
		CL_OTHER  = 4'd8,
		CL_SPACE  = 4'd9
	} cls_t;

	typedef enum logic [2:0] {
		TC_RESERVED = 3'd0,
		TC_IDENT    = 3'd1,
		TC_NUMBER   = 3'd2,
		TC_ERROR    = 3'd3,
		TC_SYMBOL   = 3'd4
	} tcls_t;

	// one classified character with its source position
	typedef struct packed {
		logic [7:0]        ch;
		cls_t              cls;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
	} chr_t;

	typedef struct packed {
		tcls_t             tcls;
		logic [2:0]        idx;
		logic [LEN_W-1:0]  len;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
	} tok_t;

endpackage

FILE: rtl/table_driven_token_scanner.sv
// Lexical scanner for a small C-like language: one source byte per transaction in, one token
// per transaction out. The front end classifies each byte and tags it with its line and
// column, then places it in a short queue (QUEUE_DEPTH entries); the back end runs the scanner
// state machine on the queue head and loads the resulting tokens into a two-entry output stage.
// Sustained rate is one byte per cycle while the output side keeps up. A byte that closes one
// token and also forms a single-character token of its own yields two tokens, which leave
// the output stage one after the other; the queue absorbs that and other output stalls. Comments
// and whitespace produce no token. Token length saturates at TOKEN_LENGTH_LIMIT and is reported
// in ten bits; line and column saturate at their field maxima.
module table_driven_token_scanner #(
	parameter int TOKEN_LENGTH_LIMIT = tdts_pkg::LENGTH_LIMIT_DEF,
	parameter int QUEUE_DEPTH = tdts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    character,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    token_class,
	output logic [2:0]                    reserved_index,
	output logic [tdts_pkg::LEN_W-1:0]    token_length,
	output logic [tdts_pkg::LINE_W-1:0]   line_number,
	output logic [tdts_pkg::COL_W-1:0]    end_column,
	output logic                          last
);
	import tdts_pkg::*;

	logic push;
	chr_t push_data;
	logic queue_full;
	logic pop;
	logic head_valid;
	chr_t head_data;
	tok_t tok;

	tdts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	tdts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	tdts_back #(
		.LENGTH_LIMIT (TOKEN_LENGTH_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tok_out    (tok),
		.last       (last)
	);

	assign token_class    = tok.tcls;
	assign reserved_index = tok.idx;
	assign token_length   = tok.len;
	assign line_number    = tok.line;
	assign end_column     = tok.col;

endmodule

FILE: rtl/tdts_front.sv
module tdts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       character,
	output logic             push,
	output tdts_pkg::chr_t   push_data,
	input  logic             queue_full
);
	import tdts_pkg::*;

	logic [LINE_W-1:0] line_q;
	logic [COL_W-1:0]  col_q;

	function automatic cls_t class_of(input logic [7:0] c);
		cls_t k;
		case (c) inside
			"+", "-", ";", ",", "(", ")", "[", "]", "{", "}": k = CL_SYM;
			["0":"9"]:                                        k = CL_DIGIT;
			["a":"z"], ["A":"Z"]:                             k = CL_LETTER;
			"/":                                              k = CL_SLASH;
			"*":                                              k = CL_STAR;
			"<", ">":                                         k = CL_REL;
			"=":                                              k = CL_EQ;
			"!":                                              k = CL_BANG;
			" ", 8'h09, 8'h0a:                                k = CL_SPACE;
			default:                                          k = CL_OTHER;
		endcase
		return k;
	endfunction

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	assign push_data.ch   = character;
	assign push_data.cls  = class_of(character);
	assign push_data.line = line_q;
	assign push_data.col  = col_q;

	// position counters saturate at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_W'(1);
			col_q  <= '0;
		end else if (push) begin
			if (character == 8'h0a) begin
				if (line_q != '1)
					line_q <= line_q + LINE_W'(1);
				col_q <= '0;
			end else if (col_q != '1) begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

FILE: rtl/tdts_queue.sv
module tdts_queue #(
	parameter int DEPTH = tdts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tdts_pkg::chr_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output tdts_pkg::chr_t head_data
);
	import tdts_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	chr_t           mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/tdts_back.sv
module tdts_back #(
	parameter int LENGTH_LIMIT = tdts_pkg::LENGTH_LIMIT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  tdts_pkg::chr_t head_data,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output tdts_pkg::tok_t tok_out,
	output logic           last
);
	import tdts_pkg::*;

	localparam int CNT_W = $clog2(LENGTH_LIMIT + 1);
	localparam int N_WORDS = 6;
	localparam int WORD_MAX = 6;

	localparam logic [7:0] WORD_CHAR [N_WORDS][WORD_MAX] = '{
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"v", "o", "i", "d", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00}
	};
	localparam logic [2:0] WORD_LEN [N_WORDS] = '{3'd4, 3'd2, 3'd3, 3'd6, 3'd4, 3'd5};

	typedef enum logic [8:0] {
		ST_START = 9'b000000001,
		ST_CMP   = 9'b000000010,
		ST_EQ    = 9'b000000100,
		ST_NOT   = 9'b000001000,
		ST_ID    = 9'b000010000,
		ST_NUM   = 9'b000100000,
		ST_SLASH = 9'b001000000,
		ST_BODY  = 9'b010000000,
		ST_STAR  = 9'b100000000
	} st_t;

	typedef struct packed {
		st_t  nxt;
		logic take;
		logic done;
		logic err;
	} step_t;

	function automatic step_t go(input st_t n);
		step_t r;
		r.nxt  = n;
		r.take = 1'b1;
		r.done = 1'b0;
		r.err  = 1'b0;
		return r;
	endfunction

	function automatic step_t stop(input logic take, input logic err);
		step_t r;
		r.nxt  = ST_START;
		r.take = take;
		r.done = !err;
		r.err  = err;
		return r;
	endfunction

	function automatic step_t dfa_step(input st_t s, input cls_t k);
		step_t r;
		case (s)
			ST_START: begin
				case (k)
					CL_SYM, CL_STAR: r = stop(1'b1, 1'b0);
					CL_DIGIT:        r = go(ST_NUM);
					CL_LETTER:       r = go(ST_ID);
					CL_SLASH:        r = go(ST_SLASH);
					CL_REL, CL_EQ:   r = go(ST_CMP);
					CL_BANG:         r = go(ST_NOT);
					CL_SPACE:        r = go(ST_START);
					default:         r = stop(1'b1, 1'b1);
				endcase
			end
			ST_CMP:   r = (k == CL_EQ) ? go(ST_EQ) : stop(1'b0, 1'b0);
			ST_EQ:    r = stop(1'b0, 1'b0);
			ST_NOT:   r = (k == CL_EQ) ? stop(1'b1, 1'b0) : stop(1'b0, 1'b1);
			ST_ID:    r = (k == CL_LETTER) ? go(ST_ID) : stop(1'b0, 1'b0);
			ST_NUM:   r = (k == CL_DIGIT) ? go(ST_NUM) : stop(1'b0, 1'b0);
			ST_SLASH: r = (k == CL_STAR) ? go(ST_BODY) : stop(1'b0, 1'b0);
			ST_BODY:  r = (k == CL_STAR) ? go(ST_STAR) : go(ST_BODY);
			ST_STAR: begin
				case (k)
					CL_SLASH: r = go(ST_START);
					CL_STAR:  r = go(ST_STAR);
					default:  r = go(ST_BODY);
				endcase
			end
			default:  r = stop(1'b0, 1'b0);
		endcase
		return r;
	endfunction

	function automatic tok_t make_tok(input logic err, input logic [CNT_W-1:0] cnt,
			input logic fl, input logic fd, input logic [N_WORDS-1:0] match,
			input logic [COL_W-1:0] endcol, input logic [LINE_W-1:0] line);
		tok_t       t;
		logic       hit;
		logic [2:0] idx;
		hit = 1'b0;
		idx = '0;
		// scan downwards so the lowest matching word wins
		for (int w = N_WORDS - 1; w >= 0; w--) begin
			if (match[w] && cnt == CNT_W'(WORD_LEN[w])) begin
				hit = 1'b1;
				idx = 3'(w);
			end
		end
		if (err)
			t.tcls = TC_ERROR;
		else if (fl)
			t.tcls = hit ? TC_RESERVED : TC_IDENT;
		else if (fd)
			t.tcls = TC_NUMBER;
		else
			t.tcls = TC_SYMBOL;
		t.idx  = (!err && fl && hit) ? idx : 3'd0;
		t.len  = LEN_W'(cnt);
		t.line = line;
		t.col  = endcol;
		return t;
	endfunction

	// scanner state
	st_t                st_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               first_letter_q;
	logic               first_digit_q;
	logic [N_WORDS-1:0] match_q;
	logic [COL_W-1:0]   endcol_q;

	// output stage, up to two tokens from one character
	logic av_s1;
	logic bv_s1;
	tok_t a_s1;
	tok_t b_s1;

	step_t              s1;
	step_t              s2;
	logic [CNT_W-1:0]   cnt_inc;
	logic [2:0]         pos;
	logic [N_WORDS-1:0] match_kept;
	logic [N_WORDS-1:0] match_fresh;
	logic               fl_kept;
	logic               fd_kept;

	st_t                nst;
	logic [CNT_W-1:0]   ncnt;
	logic               nfl;
	logic               nfd;
	logic [N_WORDS-1:0] nmatch;
	logic [COL_W-1:0]   nend;
	logic               ta_v;
	logic               tb_v;
	tok_t               ta;
	tok_t               tb;
	logic               free;

	assign s1 = dfa_step(st_q, head_data.cls);
	assign s2 = dfa_step(ST_START, head_data.cls);

	assign cnt_inc = (cnt_q == CNT_W'(LENGTH_LIMIT)) ? cnt_q : cnt_q + CNT_W'(1);
	assign pos     = (cnt_q < CNT_W'(WORD_MAX)) ? cnt_q[2:0] : 3'd0;
	assign fl_kept = (cnt_q == '0) ? (head_data.cls == CL_LETTER) : first_letter_q;
	assign fd_kept = (cnt_q == '0) ? (head_data.cls == CL_DIGIT) : first_digit_q;

	always_comb begin
		for (int w = 0; w < N_WORDS; w++) begin
			match_fresh[w] = (head_data.ch == WORD_CHAR[w][0]);
			if (cnt_q == '0)
				match_kept[w] = match_fresh[w];
			else
				match_kept[w] = match_q[w] && (cnt_q < CNT_W'(WORD_MAX))
					&& (head_data.ch == WORD_CHAR[w][pos]);
		end
	end

	always_comb begin
		nst    = st_q;
		ncnt   = cnt_q;
		nfl    = first_letter_q;
		nfd    = first_digit_q;
		nmatch = match_q;
		nend   = endcol_q;
		ta_v   = 1'b0;
		tb_v   = 1'b0;
		ta     = '0;
		tb     = '0;
		if (s1.take) begin
			if (!s1.done && !s1.err && s1.nxt == ST_START) begin
				ncnt = '0;
			end else if (s1.done || s1.err || (s1.nxt != ST_BODY && s1.nxt != ST_STAR)) begin
				ncnt   = cnt_inc;
				nfl    = fl_kept;
				nfd    = fd_kept;
				nmatch = match_kept;
				nend   = head_data.col;
			end
			if (s1.done || s1.err) begin
				ta_v = (ncnt != '0);
				ta   = make_tok(s1.err, ncnt, nfl, nfd, nmatch, nend, head_data.line);
				ncnt = '0;
				nst  = ST_START;
			end else begin
				nst = s1.nxt;
			end
		end else begin
			// character ends the token unconsumed and is scanned again from start
			ta_v = (cnt_q != '0);
			ta   = make_tok(s1.err, cnt_q, first_letter_q, first_digit_q, match_q,
				endcol_q, head_data.line);
			if (!s2.done && !s2.err && s2.nxt == ST_START) begin
				ncnt = '0;
			end else begin
				ncnt   = CNT_W'(1);
				nfl    = (head_data.cls == CL_LETTER);
				nfd    = (head_data.cls == CL_DIGIT);
				nmatch = match_fresh;
				nend   = head_data.col;
			end
			if (s2.done || s2.err) begin
				tb_v = 1'b1;
				tb   = make_tok(s2.err, ncnt, nfl, nfd, nmatch, nend, head_data.line);
				ncnt = '0;
				nst  = ST_START;
			end else begin
				nst = s2.nxt;
			end
		end
	end

	assign free = (!av_s1 && !bv_s1) || (out_ready && (av_s1 ^ bv_s1));
	assign pop  = head_valid && ((!ta_v && !tb_v) || free);

	assign out_valid = av_s1 || bv_s1;
	assign tok_out   = av_s1 ? a_s1 : b_s1;
	assign last      = !(av_s1 && bv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_START;
			cnt_q <= '0;
		end else if (pop) begin
			st_q  <= nst;
			cnt_q <= ncnt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			first_letter_q <= nfl;
			first_digit_q  <= nfd;
			match_q        <= nmatch;
			endcol_q       <= nend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			av_s1 <= 1'b0;
			bv_s1 <= 1'b0;
		end else if (pop && (ta_v || tb_v)) begin
			av_s1 <= ta_v;
			bv_s1 <= tb_v;
		end else if (out_valid && out_ready) begin
			if (av_s1)
				av_s1 <= 1'b0;
			else
				bv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (ta_v || tb_v)) begin
			a_s1 <= ta;
			b_s1 <= tb;
		end
	end

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_START) |-> (cnt_q == '0))
		else $error("start state with a partial token");

	a_one_char_states: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CMP || st_q == ST_NOT || st_q == ST_SLASH || st_q == ST_BODY
			|| st_q == ST_STAR) |-> (cnt_q == CNT_W'(1)))
		else $error("single character state with wrong count");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("second token of a pair lost");

	a_reserved_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tok_out.tcls == TC_RESERVED) |->
			(tok_out.len >= LEN_W'(2) && tok_out.len <= LEN_W'(WORD_MAX)))
		else $error("reserved word with impossible length");

endmodule

FILE: tb/table_driven_token_scanner_tb.sv
`timescale 1ns / 100ps

module table_driven_token_scanner_tb;
	import tdts_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_CHARS = 125;
	localparam int KEEP_CHARS = 8;
	localparam int LEN_LIMIT = LENGTH_LIMIT_DEF;
	localparam int DIR_ROWS = 26;
	localparam int MAX_PRINTED = 40;

	typedef enum logic [3:0] {
		S_START, S_CMP, S_EQ, S_NOT, S_ID, S_NUM, S_SLASH, S_BODY, S_STAR, S_DONE, S_ERR
	} scan_st_t;

	typedef struct packed {
		tcls_t             tcls;
		logic [2:0]        idx;
		logic [LEN_W-1:0]  len;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
		logic              last;
	} token_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		token_t     tok;
	} dir_row_t;

	localparam token_t NO_TOK = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        character = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        token_class;
	logic [2:0]        reserved_index;
	logic [LEN_W-1:0]  token_length;
	logic [LINE_W-1:0] line_number;
	logic [COL_W-1:0]  end_column;
	logic              last;

	table_driven_token_scanner dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.character      (character),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.token_class    (token_class),
		.reserved_index (reserved_index),
		.token_length   (token_length),
		.line_number    (line_number),
		.end_column     (end_column),
		.last           (last)
	);

	// directed rows; typed tokens are the ones obvious from the position alone
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{"+",   1'b1, '{TC_SYMBOL, 3'd0, 10'd1, 16'd1, 10'd0, 1'b1}},
		'{"a",   1'b0, NO_TOK},
		'{"1",   1'b0, NO_TOK},
		'{";",   1'b0, NO_TOK},
		'{"!",   1'b0, NO_TOK},
		'{"x",   1'b1, '{TC_ERROR, 3'd0, 10'd1, 16'd1, 10'd4, 1'b1}},
		'{" ",   1'b0, NO_TOK},
		'{8'h00, 1'b1, '{TC_ERROR, 3'd0, 10'd1, 16'd1, 10'd7, 1'b1}},
		'{8'hFF, 1'b1, '{TC_ERROR, 3'd0, 10'd1, 16'd1, 10'd8, 1'b1}},
		'{"/",   1'b0, NO_TOK},
		'{"*",   1'b0, NO_TOK},
		'{8'h0A, 1'b0, NO_TOK},
		'{"*",   1'b0, NO_TOK},
		'{"/",   1'b0, NO_TOK},
		'{"/",   1'b0, NO_TOK},
		'{" ",   1'b1, '{TC_SYMBOL, 3'd0, 10'd1, 16'd2, 10'd2, 1'b1}},
		'{"<",   1'b0, NO_TOK},
		'{"=",   1'b0, NO_TOK},
		'{"=",   1'b1, '{TC_SYMBOL, 3'd0, 10'd2, 16'd2, 10'd5, 1'b1}},
		'{">",   1'b0, NO_TOK},
		'{"i",   1'b0, NO_TOK},
		'{"f",   1'b0, NO_TOK},
		'{"(",   1'b0, NO_TOK},
		'{"!",   1'b0, NO_TOK},
		'{"=",   1'b1, '{TC_SYMBOL, 3'd0, 10'd2, 16'd2, 10'd12, 1'b1}},
		'{8'h09, 1'b0, NO_TOK}
	};

	string res_words [6] = '{"else", "if", "int", "return", "void", "while"};
	string op_set = "+-;,()[]{}<>=!*/";

	// scanner mirror
	scan_st_t   sc_state = S_START;
	logic [7:0] kept_text [KEEP_CHARS];
	int         kept_cnt = 0;
	int         kept_col = 0;
	int         cur_line = 1;
	int         cur_col = 0;

	token_t     tok_due [$];
	logic [7:0] src_q [$];
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         hold_req = 1'b0;
	int         hold_left = 0;
	int         mism_count = 0;
	int         idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic cls_t char_class(input logic [7:0] c);
		case (c)
			"+", "-", ";", ",", "(", ")", "[", "]", "{", "}": return CL_SYM;
			"/": return CL_SLASH;
			"*": return CL_STAR;
			"<", ">": return CL_REL;
			"=": return CL_EQ;
			"!": return CL_BANG;
			8'h20, 8'h09, 8'h0A: return CL_SPACE;
			default: begin
				if (c >= "0" && c <= "9")
					return CL_DIGIT;
				if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
					return CL_LETTER;
				return CL_OTHER;
			end
		endcase
	endfunction

	// one dfa move: next state and whether the character is consumed
	function automatic void dfa_move(input scan_st_t s, input cls_t k,
			output scan_st_t ns, output logic take);
		take = 1'b0;
		ns = S_DONE;
		case (s)
			S_START: begin
				take = 1'b1;
				case (k)
					CL_DIGIT: ns = S_NUM;
					CL_LETTER: ns = S_ID;
					CL_SLASH: ns = S_SLASH;
					CL_REL, CL_EQ: ns = S_CMP;
					CL_BANG: ns = S_NOT;
					CL_OTHER: ns = S_ERR;
					CL_SPACE: ns = S_START;
					default: ns = S_DONE;
				endcase
			end
			S_CMP: if (k == CL_EQ) begin
				ns = S_EQ;
				take = 1'b1;
			end
			S_NOT: if (k == CL_EQ) begin
				take = 1'b1;
			end else begin
				ns = S_ERR;
			end
			S_ID: if (k == CL_LETTER) begin
				ns = S_ID;
				take = 1'b1;
			end
			S_NUM: if (k == CL_DIGIT) begin
				ns = S_NUM;
				take = 1'b1;
			end
			S_SLASH: if (k == CL_STAR) begin
				ns = S_BODY;
				take = 1'b1;
			end
			S_BODY: begin
				take = 1'b1;
				ns = (k == CL_STAR) ? S_STAR : S_BODY;
			end
			S_STAR: begin
				take = 1'b1;
				ns = (k == CL_SLASH) ? S_START : ((k == CL_STAR) ? S_STAR : S_BODY);
			end
			default: ns = S_DONE;
		endcase
	endfunction

	function automatic token_t make_token(input logic is_err);
		token_t t;
		logic   same;
		t = NO_TOK;
		t.tcls = TC_SYMBOL;
		if (is_err) begin
			t.tcls = TC_ERROR;
		end else if (char_class(kept_text[0]) == CL_LETTER) begin
			t.tcls = TC_IDENT;
			for (int w = 0; w < 6; w++) begin
				same = (kept_cnt == res_words[w].len());
				for (int k = 0; same && k < res_words[w].len(); k++)
					if (kept_text[k] != res_words[w][k])
						same = 1'b0;
				if (same && t.tcls == TC_IDENT) begin
					t.tcls = TC_RESERVED;
					t.idx = w[2:0];
				end
			end
		end else if (char_class(kept_text[0]) == CL_DIGIT) begin
			t.tcls = TC_NUMBER;
		end
		t.len = kept_cnt[LEN_W-1:0];
		t.line = cur_line[LINE_W-1:0];
		t.col = kept_col[COL_W-1:0];
		t.last = 1'b0;
		return t;
	endfunction

	// advances the mirror by one character, returns the number of tokens it ends
	function automatic int scan_predict(input logic [7:0] c, output token_t t0, output token_t t1);
		cls_t     k;
		scan_st_t ns;
		logic     take;
		logic     taken;
		int       n;
		k = char_class(c);
		n = 0;
		taken = 1'b0;
		t0 = NO_TOK;
		t1 = NO_TOK;
		for (int pass = 0; pass < 2 && !taken; pass++) begin
			dfa_move(sc_state, k, ns, take);
			if (take) begin
				taken = 1'b1;
				if (ns == S_START) begin
					kept_cnt = 0;
				end else if (ns != S_BODY && ns != S_STAR) begin
					if (kept_cnt < KEEP_CHARS)
						kept_text[kept_cnt] = c;
					if (kept_cnt < LEN_LIMIT)
						kept_cnt++;
					kept_col = cur_col;
				end
			end
			if (ns == S_DONE || ns == S_ERR) begin
				if (kept_cnt > 0) begin
					if (n == 0)
						t0 = make_token(ns == S_ERR);
					else
						t1 = make_token(ns == S_ERR);
					n++;
				end
				kept_cnt = 0;
				ns = S_START;
			end
			sc_state = ns;
		end
		if (n == 1)
			t0.last = 1'b1;
		else if (n == 2)
			t1.last = 1'b1;
		if (c == 8'h0A) begin
			if (cur_line < 65535)
				cur_line++;
			cur_col = 0;
		end else if (cur_col < 1023) begin
			cur_col++;
		end
		return n;
	endfunction

	task automatic push_run(input int n, input logic [7:0] lo, input logic [7:0] hi);
		for (int k = 0; k < n; k++)
			src_q.push_back(8'($urandom_range(hi, lo)));
	endtask

	task automatic send_char(input logic [7:0] c, input logic typed, input token_t typed_tok);
		token_t t0;
		token_t t1;
		int     n;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		character <= c;
		do @(posedge clk); while (!in_ready);
		n = scan_predict(c, t0, t1);
		if (typed) begin
			tok_due.push_back(typed_tok);
		end else begin
			if (n > 0)
				tok_due.push_back(t0);
			if (n > 1)
				tok_due.push_back(t1);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mism_count++;
		if (mism_count <= MAX_PRINTED)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	task automatic check_token();
		token_t want;
		if (tok_due.size() == 0) begin
			report_mismatch("token with none expected, class", token_class, -1);
		end else begin
			want = tok_due.pop_front();
			if (token_class !== want.tcls)
				report_mismatch("token_class", token_class, want.tcls);
			if (reserved_index !== want.idx)
				report_mismatch("reserved_index", reserved_index, want.idx);
			if (token_length !== want.len)
				report_mismatch("token_length", token_length, want.len);
			if (line_number !== want.line)
				report_mismatch("line_number", line_number, want.line);
			if (end_column !== want.col)
				report_mismatch("end_column", end_column, want.col);
			if (last !== want.last)
				report_mismatch("last", last, want.last);
		end
	endtask

	// token side: check each transaction, then choose ready for the next edge
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_token();
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL table_driven_token_scanner");
		$finish;
	end

	initial begin
		int    sent;
		int    pick;
		string w;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 32;
		recv_idle_pct = 47;
		for (int r = 0; r < DIR_ROWS; r++)
			send_char(dir_tab[r].ch, dir_tab[r].typed, dir_tab[r].tok);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : ((phase == 1) ? 47 : 0);
			recv_idle_pct = (phase == 0) ? 47 : ((phase == 1) ? 32 : 0);
			if (phase != 1)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_CHARS) begin
				if (src_q.size() == 0) begin
					pick = $urandom_range(99);
					if (pick < 22) begin
						// reserved word, now and then spoilt by case or a tail
						w = res_words[$urandom_range(5)];
						for (int k = 0; k < w.len(); k++)
							src_q.push_back(w[k]);
						if (pick == 16)
							src_q[src_q.size() - w.len()] ^= 8'h20;
						if (pick >= 18)
							push_run($urandom_range(3, 1), "a", "z");
					end else if (pick < 34) begin
						for (int k = $urandom_range(10, 1); k > 0; k--)
							if ($urandom_range(1))
								push_run(1, "a", "z");
							else
								push_run(1, "A", "Z");
					end else if (pick < 46) begin
						push_run($urandom_range(6, 1), "0", "9");
					end else if (pick < 66) begin
						src_q.push_back(op_set[$urandom_range(op_set.len() - 1)]);
						if ($urandom_range(1))
							src_q.push_back("=");
					end else if (pick < 74) begin
						src_q.push_back("/");
						src_q.push_back("*");
						for (int k = $urandom_range(8, 0); k > 0; k--)
							case ($urandom_range(3))
								0: push_run(1, 8'h00, 8'hFF);
								1: src_q.push_back("*");
								2: src_q.push_back(8'h0A);
								default: push_run(1, "a", "z");
							endcase
						src_q.push_back("*");
						src_q.push_back("/");
					end else if (pick < 86) begin
						src_q.push_back(" ");
					end else begin
						push_run(1, 8'h00, 8'hFF);
					end
					// whitespace between lexemes or none, so tokens also abut
					case ($urandom_range(5))
						0: src_q.push_back(" ");
						1: src_q.push_back(8'h09);
						2: src_q.push_back(8'h0A);
						default: ;
					endcase
				end
				send_char(src_q.pop_front(), 1'b0, NO_TOK);
				sent++;
			end
		end

		// close any comment left open by the random part
		send_idle_pct = 0;
		recv_idle_pct = 0;
		src_q.push_back(" ");
		src_q.push_back("*");
		src_q.push_back("/");
		// saturation: token length and column counters
		src_q.push_back(8'h0A);
		push_run(1030, "a", "z");
		src_q.push_back(" ");
		w = "int x;while(y!=0)";
		for (int k = 0; k < w.len(); k++)
			src_q.push_back(w[k]);
		src_q.push_back(8'h0A);
		while (src_q.size() > 0)
			send_char(src_q.pop_front(), 1'b0, NO_TOK);
		in_valid <= 1'b0;

		while (tok_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mism_count == 0)
			$display("PASS table_driven_token_scanner");
		else
			$display("FAIL table_driven_token_scanner");
		$finish;
	end

endmodule

FILE: files.f
rtl/tdts_pkg.sv
rtl/tdts_front.sv
rtl/tdts_queue.sv
rtl/tdts_back.sv
rtl/table_driven_token_scanner.sv
tb/table_driven_token_scanner_tb.sv
